// ===== design/multi_level_priority_queue_macros.svh =====
// Assertion macros used by the assertion checker of the priority queue.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef MULTI_LEVEL_PRIORITY_QUEUE_MACROS_SVH
`define MULTI_LEVEL_PRIORITY_QUEUE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MLPQ_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed in priority queue checker");

// Next-cycle implication, disabled while reset is asserted.
`define MLPQ_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed in priority queue checker");

`endif

// ===== design/mlpq_pkg.sv =====
// Package of the multi-level priority queue: operation and status codes.
// Depends on nothing; used by the top level, both checkers and the testbench.
package mlpq_pkg;

  typedef logic [1:0] status_t;

  localparam logic    FUNC_INSERT = 1'b0;
  localparam logic    FUNC_DELETE = 1'b1;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_FULL  = 2'd1;
  localparam status_t ST_EMPTY = 2'd2;

  localparam logic signed [31:0] EMPTY_WORD = -32'sd1;
  localparam logic signed [31:0] ZERO_WORD  = 32'sd0;

endpackage

// ===== design/mlpq_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module mlpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/mlpq_pick.sv =====
// Priority encoder that finds the highest non-empty level.
// Depends on nothing; used by the top level.
module mlpq_pick #(
  parameter int NUM_LEVELS = 8
) (
  input  logic [NUM_LEVELS-1:0]         nonempty,
  output logic                          found,
  output logic [$clog2(NUM_LEVELS)-1:0] level
);

  localparam int LVL_W = $clog2(NUM_LEVELS);

  // Later (higher) levels override earlier ones.
  always_comb begin
    found = 1'b0;
    level = '0;
    for (int i = 0; i < NUM_LEVELS; i++) begin
      if (nonempty[i]) begin
        found = 1'b1;
        level = LVL_W'(i);
      end
    end
  end

endmodule

// ===== design/multi_level_priority_queue.sv =====
// Top level of the multi-level priority queue: ring pointers, decision logic
// and result register. Depends on mlpq_pkg, mlpq_pick and mlpq_ram.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+-------------------------------
//   input    | in_valid / in_stall   | func, data, priority_req
//   output   | out_valid / out_stall | data_out, status
//
// One operation is accepted per cycle while the output is not stalled; its result appears in the next cycle.
// Each operation makes at most one access to the entry RAM, which sets the rate.
// Reset clears every ring's head and count; the entry RAM is not cleared.
// The input is stalled only while a finished result waits on a stalled output.
module multi_level_priority_queue
  import mlpq_pkg::*;
#(
  parameter int NUM_LEVELS  = 8,
  parameter int LEVEL_DEPTH = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               func,
  input  logic signed [31:0] data,
  input  logic [3:0]         priority_req,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] data_out,
  output logic [1:0]         status
);

  localparam int LVL_W  = $clog2(NUM_LEVELS);
  localparam int PTR_W  = $clog2(LEVEL_DEPTH);
  localparam int CNT_W  = $clog2(LEVEL_DEPTH + 1);
  localparam int SUM_W  = PTR_W + 1;
  localparam int MEM_D  = NUM_LEVELS * LEVEL_DEPTH;
  localparam int ADDR_W = $clog2(MEM_D);
  // Wide enough to hold both a 4-bit priority and the level count itself.
  localparam int PRI_W  = 6;

  // Per-level ring state: the slot of the oldest word and the number held.
  logic [PTR_W-1:0] head  [NUM_LEVELS];
  logic [CNT_W-1:0] count [NUM_LEVELS];

  logic [NUM_LEVELS-1:0] nonempty;
  logic                  found;
  logic [LVL_W-1:0]      pick_lvl;

  logic                  accept;
  logic                  is_insert;
  logic                  prio_ok;
  logic                  ins_ok;
  logic [LVL_W-1:0]      ins_lvl;
  logic [SUM_W-1:0]      tail_sum;
  logic [PTR_W-1:0]      tail_slot;
  logic [PTR_W-1:0]      pick_head;
  logic [PTR_W-1:0]      pick_head_next;
  logic [ADDR_W-1:0]     waddr;
  logic [ADDR_W-1:0]     raddr;
  logic                  do_write;
  logic                  do_read;
  logic [31:0]           rdata;

  // Result register: status, and whether the word comes from the RAM.
  status_t               status_q;
  logic                  from_ram;

  always_comb begin
    for (int i = 0; i < NUM_LEVELS; i++) begin
      nonempty[i] = (count[i] != '0);
    end
  end

  mlpq_pick #(
    .NUM_LEVELS (NUM_LEVELS)
  ) u_pick (
    .nonempty (nonempty),
    .found    (found),
    .level    (pick_lvl)
  );

  // An output slot is free when nothing is held or the held result leaves now.
  assign in_stall  = out_valid && out_stall;
  assign accept    = in_valid && !in_stall;
  assign is_insert = (func == FUNC_INSERT);

  // A priority of zero or above the level count behaves like a full level.
  assign prio_ok = (priority_req != 4'd0) &&
                   ({2'b00, priority_req} <= PRI_W'(NUM_LEVELS));
  assign ins_lvl = LVL_W'(priority_req - 4'd1);
  assign ins_ok  = prio_ok && (count[ins_lvl] != CNT_W'(LEVEL_DEPTH));

  // Tail slot of the insert ring: head plus count, wrapped once.
  always_comb begin
    tail_sum = SUM_W'(head[ins_lvl]) + SUM_W'(count[ins_lvl]);
    if (tail_sum >= SUM_W'(LEVEL_DEPTH)) begin
      tail_slot = PTR_W'(tail_sum - SUM_W'(LEVEL_DEPTH));
    end else begin
      tail_slot = PTR_W'(tail_sum);
    end
  end

  assign pick_head      = head[pick_lvl];
  assign pick_head_next = (pick_head == PTR_W'(LEVEL_DEPTH - 1)) ? '0 : pick_head + 1'b1;

  assign waddr = ADDR_W'(ins_lvl) * ADDR_W'(LEVEL_DEPTH) + ADDR_W'(tail_slot);
  assign raddr = ADDR_W'(pick_lvl) * ADDR_W'(LEVEL_DEPTH) + ADDR_W'(pick_head);

  assign do_write = accept && is_insert && ins_ok;
  assign do_read  = accept && !is_insert && found;

  // A read in the cycle after a write to the same slot sees the new word,
  // since the write lands at the edge that accepts the insert.
  mlpq_ram #(
    .WIDTH (32),
    .DEPTH (MEM_D)
  ) u_store (
    .clk   (clk),
    .we    (do_write),
    .waddr (waddr),
    .wdata ($unsigned(data)),
    .re    (do_read),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Ring pointers move at the edge that accepts the operation, so the next
  // operation already sees the updated state.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_LEVELS; i++) begin
        head[i]  <= '0;
        count[i] <= '0;
      end
    end else begin
      if (do_write) begin
        count[ins_lvl] <= count[ins_lvl] + 1'b1;
      end
      if (do_read) begin
        count[pick_lvl] <= count[pick_lvl] - 1'b1;
        head[pick_lvl]  <= pick_head_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // The RAM read data holds while the result waits, because no new read is
  // issued until the held result has been transferred.
  always_ff @(posedge clk) begin
    if (accept) begin
      from_ram <= do_read;
      if (is_insert) begin
        status_q <= ins_ok ? ST_OK : ST_FULL;
      end else begin
        status_q <= found ? ST_OK : ST_EMPTY;
      end
    end
  end

  always_comb begin
    if (from_ram) begin
      data_out = $signed(rdata);
    end else if (status_q == ST_EMPTY) begin
      data_out = EMPTY_WORD;
    end else begin
      data_out = ZERO_WORD;
    end
  end

  assign status = status_q;

endmodule

// ===== design/mlpq_checker.sv =====
// Port-level checker for the multi-level priority queue, bound to the top level.
// Depends on mlpq_pkg and multi_level_priority_queue_macros.svh.
`include "multi_level_priority_queue_macros.svh"

module mlpq_assertions
  import mlpq_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [31:0] data_out,
  input logic [1:0]         status
);

  // The input is held back only by a result waiting on a stalled output.
  `MLPQ_ASSERT_IMP(a_stall_cause, in_stall, out_valid && out_stall)

  // Every accepted operation yields a result in the next cycle.
  `MLPQ_ASSERT_NXT(a_one_result, in_valid && !in_stall, out_valid)

  // An empty delete returns all ones; a full insert returns zero.
  `MLPQ_ASSERT_IMP(a_empty_word, out_valid && (status == ST_EMPTY), data_out == EMPTY_WORD)
  `MLPQ_ASSERT_IMP(a_full_word, out_valid && (status == ST_FULL), data_out == ZERO_WORD)

  // A stalled result keeps its payload.
  `MLPQ_ASSERT_NXT(a_hold, out_valid && out_stall,
                   out_valid && $stable(data_out) && $stable(status))

endmodule

bind multi_level_priority_queue mlpq_assertions u_mlpq_checker (.*);

// ===== test/mlpq_checker.sv =====
// Checker of the multi-level priority queue: predicts each result from the
// accepted operations and compares it with the output transfers.
// Depends on mlpq_pkg for the operation and status codes.
module mlpq_checker
  import mlpq_pkg::*;
#(
  parameter int NUM_LEVELS  = 8,
  parameter int LEVEL_DEPTH = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic               func,
  input  logic signed [31:0] data,
  input  logic [3:0]         priority_req,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [31:0] data_out,
  input  logic [1:0]         status,
  output int                 fail_count,
  output int                 pending,
  output int                 n_insert,
  output int                 n_delete,
  output int                 n_full,
  output int                 n_empty
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [31:0] word;
    status_t            st;
  } outcome_t;

  // Own copy of the rings: stored words, oldest slot and fill per level.
  logic signed [31:0] ring_word [NUM_LEVELS][LEVEL_DEPTH];
  int                 ring_head [NUM_LEVELS];
  int                 ring_fill [NUM_LEVELS];

  outcome_t outcome_q [$];

  function automatic outcome_t compute_outcome(logic op, logic signed [31:0] word,
                                               logic [3:0] prio);
    outcome_t res;
    int       lvl;
    int       slot;
    bit       found;
    res.word = ZERO_WORD;
    res.st   = ST_OK;
    found    = 1'b0;
    if (op == FUNC_INSERT) begin
      n_insert++;
      lvl = int'(prio) - 1;
      if (prio == 4'd0 || int'(prio) > NUM_LEVELS) begin
        res.st = ST_FULL;
      end else if (ring_fill[lvl] >= LEVEL_DEPTH) begin
        res.st = ST_FULL;
      end else begin
        slot = (ring_head[lvl] + ring_fill[lvl]) % LEVEL_DEPTH;
        ring_word[lvl][slot] = word;
        ring_fill[lvl]++;
      end
      if (res.st == ST_FULL) n_full++;
    end else begin
      n_delete++;
      for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
        if (!found && ring_fill[i] != 0) begin
          found        = 1'b1;
          res.word     = ring_word[i][ring_head[i]];
          ring_head[i] = (ring_head[i] + 1) % LEVEL_DEPTH;
          ring_fill[i]--;
        end
      end
      if (!found) begin
        res.word = EMPTY_WORD;
        res.st   = ST_EMPTY;
        n_empty++;
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin : watch
    outcome_t want;
    if (rst) begin
      for (int i = 0; i < NUM_LEVELS; i++) begin
        ring_head[i] = 0;
        ring_fill[i] = 0;
      end
      outcome_q.delete();
      fail_count = 0;
      n_insert   = 0;
      n_delete   = 0;
      n_full     = 0;
      n_empty    = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (outcome_q.size() == 0) begin
          $error("result transfer with no result expected: data_out=%0d status=%0d",
                 data_out, status);
          fail_count++;
        end else begin
          want = outcome_q.pop_front();
          if (data_out !== want.word) begin
            $error("data_out: expected %0d, actual %0d", want.word, data_out);
            fail_count++;
          end
          if (status !== want.st) begin
            $error("status: expected %0d, actual %0d", want.st, status);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall)
        outcome_q.push_back(compute_outcome(func, data, priority_req));
    end
    pending = outcome_q.size();
  end

endmodule

// ===== test/tb_multi_level_priority_queue.sv =====
// Testbench top of the multi-level priority queue: clock, reset, stimulus and
// the final verdict. Depends on mlpq_pkg, the block and mlpq_checker.
module tb_multi_level_priority_queue;
  import mlpq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_LEVELS  = 8;
  localparam int LEVEL_DEPTH = 8;
  localparam int RAND_CHUNKS = 19;
  localparam int CHUNK_ITEMS = 50;

  // Every input of the block starts at a known value; reset is held high
  // from time zero.
  logic               clk          = 1'b0;
  logic               rst          = 1'b1;
  logic               in_valid     = 1'b0;
  logic               func         = FUNC_INSERT;
  logic signed [31:0] data         = '0;
  logic [3:0]         priority_req = 4'd1;
  logic               out_stall    = 1'b0;
  logic               in_stall;
  logic               out_valid;
  logic signed [31:0] data_out;
  logic [1:0]         status;

  // Random idling on both channels is enabled only while this is set.
  logic idle_on = 1'b0;
  int   stall_left = 0;

  int fail_count, pending, n_insert, n_delete, n_full, n_empty;

  always #5 clk = ~clk;

  multi_level_priority_queue #(
    .NUM_LEVELS (NUM_LEVELS),
    .LEVEL_DEPTH(LEVEL_DEPTH)
  ) u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .func        (func),
    .data        (data),
    .priority_req(priority_req),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .data_out    (data_out),
    .status      (status)
  );

  mlpq_checker #(
    .NUM_LEVELS (NUM_LEVELS),
    .LEVEL_DEPTH(LEVEL_DEPTH)
  ) u_checker (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .func        (func),
    .data        (data),
    .priority_req(priority_req),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .data_out    (data_out),
    .status      (status),
    .fail_count  (fail_count),
    .pending     (pending),
    .n_insert    (n_insert),
    .n_delete    (n_delete),
    .n_full      (n_full),
    .n_empty     (n_empty)
  );

  // The receiver stalls in random bursts, independent of out_valid.
  always @(posedge clk) begin
    if (rst || !idle_on) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 8) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Presents one operation and returns at the clock edge of its transfer.
  // An optional idle gap goes first; valid is lowered and raised in
  // different time steps, and the payload holds while the input is stalled.
  task automatic send_item(input logic op, input logic signed [31:0] word,
                           input logic [3:0] prio);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    func         <= op;
    data         <= word;
    priority_req <= prio;
    @(posedge clk);
    // in_stall read here is the value before the edge, so a low value means
    // the transfer happened at this edge.
    while (in_stall) @(posedge clk);
  endtask

  // Stops sending and waits until every predicted result has come out.
  // The checker's counters are read on the falling edge to stay clear of
  // its updates at the rising edge.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    @(posedge clk);
  endtask

  function automatic logic signed [31:0] pick_word();
    case ($urandom_range(0, 11))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return 32'sd0;
      3:       return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  // Time limit on the whole run; far above the slowest correct run.
  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin : stimulus
    int ins_pct;
    int lo;
    int hi;
    bit narrow;
    logic op;
    logic [3:0] prio;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, no idling. A delete on the empty queue comes first.
    send_item(FUNC_DELETE, 32'sd5, 4'd3);
    // Extreme words on the extreme levels, plus a word equal to the empty
    // marker, then deletes that must come back highest level first.
    send_item(FUNC_INSERT, 32'sh7FFF_FFFF, 4'd1);
    send_item(FUNC_INSERT, 32'sh8000_0000, 4'd8);
    send_item(FUNC_INSERT, 32'sd0,         4'd4);
    send_item(FUNC_INSERT, -32'sd1,        4'd2);
    repeat (4) send_item(FUNC_DELETE, $urandom, 4'($urandom_range(0, 15)));
    send_item(FUNC_DELETE, 32'sh7FFF_FFFF, 4'd8);
    // Fill the top level to capacity; the next insert there is dropped.
    for (int i = 0; i < LEVEL_DEPTH; i++) send_item(FUNC_INSERT, $urandom, 4'd8);
    send_item(FUNC_INSERT, 32'sh1234_5678, 4'd8);
    // A few deletes, then refills so that the ring pointer wraps.
    repeat (3) send_item(FUNC_DELETE, 32'sd0, 4'd1);
    repeat (2) send_item(FUNC_INSERT, $urandom, 4'd8);
    wait_drained();

    // Random part in chunks. Each chunk leans toward inserts or deletes and
    // may crowd a narrow band of levels so that rings fill, wrap and empty.
    for (int c = 0; c < RAND_CHUNKS; c++) begin
      idle_on <= (c < RAND_CHUNKS - 3) ? ($urandom_range(0, 4) != 0) : 1'b0;
      case ($urandom_range(0, 3))
        0:       ins_pct = 20;
        1:       ins_pct = 50;
        2:       ins_pct = 75;
        default: ins_pct = 95;
      endcase
      narrow = ($urandom_range(0, 2) == 0);
      lo     = $urandom_range(1, NUM_LEVELS);
      hi     = (lo < NUM_LEVELS) ? lo + 1 : lo;
      for (int k = 0; k < CHUNK_ITEMS; k++) begin
        op   = ($urandom_range(0, 99) < ins_pct) ? FUNC_INSERT : FUNC_DELETE;
        prio = narrow ? 4'($urandom_range(lo, hi)) : 4'($urandom_range(1, NUM_LEVELS));
        send_item(op, pick_word(), prio);
      end
      // The sender holds off until all results are in at the midpoint, and
      // now and then at other chunk boundaries.
      if (c == RAND_CHUNKS / 2 || $urandom_range(0, 3) == 0)
        wait_drained();
    end

    // End: let every expected result arrive, then a short quiet tail.
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (16) @(posedge clk);
    @(negedge clk);
    $display("Run covered %0d inserts (%0d dropped on a full level) and %0d deletes",
             n_insert, n_full, n_delete);
    $display("(%0d on an empty queue), with random idling on both channels.", n_empty);
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
